### src/pal_pkg.sv
// shared types and defaults for the positional array list core
// no dependencies; imported by pal_cell and positional_array_list_core
package pal_pkg;

    localparam int DEPTH_DEF         = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        MD_INSERT = 2'd0,
        MD_DELETE = 2'd1,
        MD_FIND   = 2'd2,
        MD_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY,
        S_LAST
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // copy next entry value into the read chain
        logic shift;  // move the read chain one cell toward cell 0
        logic ins;    // open a slot at sel and write the value there
        logic del;    // close the slot at sel
    } t_cell_ctl;

endpackage

### src/pal_cell.sv
// one list cell: a stored entry plus one stage of the read chain
// depends on pal_pkg (t_cell_ctl)
module pal_cell #(
    parameter int W   = 32,
    parameter int LW  = 7,
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  pal_pkg::t_cell_ctl  i_ctl,
    input  logic [LW-1:0]       i_sel,
    input  logic [W-1:0]        i_value,
    input  logic [W-1:0]        i_prev,
    input  logic [W-1:0]        i_next,
    input  logic [W-1:0]        i_next_rd,
    output logic [W-1:0]        o_entry,
    output logic [W-1:0]        o_rd
);
    import pal_pkg::*;

    localparam logic [LW-1:0] MY = LW'(IDX);

    logic [W-1:0] r_entry, n_entry;
    logic [W-1:0] r_rd;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (MY == i_sel) begin
                n_entry = i_value;
            end else if (MY > i_sel) begin
                n_entry = i_prev;
            end
        end else if (i_ctl.del) begin
            if (MY >= i_sel) begin
                n_entry = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        // read chain sees the entry as it is after this cycle's update
        if (i_ctl.load) begin
            r_rd <= n_entry;
        end else if (i_ctl.shift) begin
            r_rd <= i_next_rd;
        end
    end

    assign o_entry = r_entry;
    assign o_rd    = r_rd;

endmodule

### src/positional_array_list_core.sv
// top level of the positional array list: sequencer, output register, cell chain
// depends on pal_pkg and pal_cell
//
//  channel  valid    ready    word
//  in       i_valid  o_ready  i_mode, i_value, i_position
//  out      o_valid  i_ready  o_status, o_found_index, o_count, o_empty_flag,
//                             o_full_flag, o_last_value
//
// one word goes through accept, a search walk for find and delete (over at most
// the old length, none for insert and clear), the apply step and a walk of the
// read chain over the new length to fetch the last entry.
// both walks move the read chain one cell per cycle toward cell 0.
// reset clears the length and the control; entries hold no reset value.
// a result waiting in the output register does not block the next accept;
// the sequencer holds its final step until that register is free.
module positional_array_list_core #(
    parameter int DEPTH         = pal_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = pal_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_found_index,
    output logic [6:0]  o_count,
    output logic        o_empty_flag,
    output logic        o_full_flag,
    output logic [31:0] o_last_value
);
    import pal_pkg::*;

    localparam int W  = ELEMENT_WIDTH;
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(DEPTH);
    localparam logic [LW-1:0] ONE      = LW'(1);

    t_state        r_state, n_state;
    t_mode         r_mode;
    logic [W-1:0]  r_val;
    logic [6:0]    r_pos;
    logic [LW-1:0] r_k, n_k;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_hit, n_hit;
    t_status       r_status, n_status;

    logic          r_ov;
    t_status       r_o_status;
    logic [LW-1:0] r_o_idx;
    logic [LW-1:0] r_o_len;
    logic [31:0]   r_o_last;

    t_cell_ctl     w_ctl;
    logic [LW-1:0] w_sel;
    logic          w_in_acc;
    logic          w_out_ld;
    logic [63:0]   w_val64;
    logic [63:0]   w_rd64;
    logic [63:0]   w_idx64;
    logic [63:0]   w_len64;

    logic [W-1:0]  w_entry [DEPTH];
    logic [W-1:0]  w_rd    [DEPTH];

    // sign-extend the input word, then keep the element width
    assign w_val64  = 64'(signed'(i_value));
    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_rd64   = 64'(w_rd[0]);

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_len    = r_len;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_status = r_status;
        w_ctl    = '0;
        w_sel    = r_idx;
        w_out_ld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_ctl.load = 1'b1;
                    n_k        = '0;
                    if (t_mode'(i_mode) == MD_FIND || t_mode'(i_mode) == MD_DELETE) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_SEARCH: begin
                if (r_k == r_len) begin
                    n_status = ST_NOTFOUND;
                    n_hit    = 1'b0;
                    n_idx    = '0;
                    n_state  = S_APPLY;
                end else if (w_rd[0] == r_val) begin
                    n_status = ST_OK;
                    n_hit    = 1'b1;
                    n_idx    = r_k;
                    n_state  = S_APPLY;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_k         = r_k + ONE;
                end
            end
            S_APPLY: begin
                unique case (r_mode)
                    MD_INSERT: begin
                        n_idx = '0;
                        if (r_len == LEN_FULL) begin
                            n_status = ST_FULL;
                        end else if (64'(r_pos) > 64'(r_len)) begin
                            n_status = ST_BADPOS;
                        end else begin
                            n_status  = ST_OK;
                            w_ctl.ins = 1'b1;
                            w_sel     = LW'(r_pos);
                            n_len     = r_len + ONE;
                        end
                    end
                    MD_DELETE: begin
                        if (r_hit) begin
                            w_ctl.del = 1'b1;
                            w_sel     = r_idx;
                            n_len     = r_len - ONE;
                        end
                    end
                    MD_FIND: begin
                    end
                    MD_CLEAR: begin
                        n_idx    = '0;
                        n_status = ST_OK;
                        n_len    = '0;
                    end
                    default: begin
                    end
                endcase
                w_ctl.load = 1'b1;
                n_k        = '0;
                n_state    = S_LAST;
            end
            S_LAST: begin
                if (r_len == '0 || (r_k + ONE) == r_len) begin
                    if (!r_ov || i_ready) begin
                        w_out_ld = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else begin
                    w_ctl.shift = 1'b1;
                    n_k         = r_k + ONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (w_out_ld) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_status <= n_status;
        if (w_in_acc) begin
            r_mode <= t_mode'(i_mode);
            r_val  <= w_val64[W-1:0];
            r_pos  <= i_position;
        end
        if (w_out_ld) begin
            r_o_status <= r_status;
            r_o_idx    <= r_idx;
            r_o_len    <= r_len;
            r_o_last   <= (r_len == '0) ? 32'd0 : w_rd64[31:0];
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [W-1:0] w_prev, w_next, w_next_rd;
            if (gi == 0) begin : g_first
                assign w_prev = w_entry[gi];
            end else begin : g_mid
                assign w_prev = w_entry[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_end
                assign w_next    = w_entry[gi];
                assign w_next_rd = w_rd[gi];
            end else begin : g_inner
                assign w_next    = w_entry[gi+1];
                assign w_next_rd = w_rd[gi+1];
            end
            pal_cell #(
                .W   (W),
                .LW  (LW),
                .IDX (gi)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_sel     (w_sel),
                .i_value   (r_val),
                .i_prev    (w_prev),
                .i_next    (w_next),
                .i_next_rd (w_next_rd),
                .o_entry   (w_entry[gi]),
                .o_rd      (w_rd[gi])
            );
        end
    endgenerate

    assign w_idx64       = 64'(r_o_idx);
    assign w_len64       = 64'(r_o_len);
    assign o_valid       = r_ov;
    assign o_status      = r_o_status;
    assign o_found_index = w_idx64[5:0];
    assign o_count       = w_len64[6:0];
    assign o_empty_flag  = (r_o_len == '0);
    assign o_full_flag   = (r_o_len == LEN_FULL);
    assign o_last_value  = r_o_last;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_FULL)
        else $error("list length beyond depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state != S_IDLE)
        else $error("sequencer stayed idle after accept");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEARCH |-> r_k <= r_len)
        else $error("search walked past the list end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |-> !w_out_ld)
        else $error("result overwritten while stalled");

endmodule
